// ===== rtl/core/ppg_sensor_sample_fifo_registers_core_assert.svh =====
// assertion macros shared by the sample fifo core rtl
// needs clk and rst_n in the scope of each use
`ifndef PPG_SENSOR_SAMPLE_FIFO_REGISTERS_CORE_ASSERT_SVH
`define PPG_SENSOR_SAMPLE_FIFO_REGISTERS_CORE_ASSERT_SVH

`ifndef SYNTH
// checked only out of reset
`define PPGSF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ppgsf check failed");
// checked on every edge, reset included
`define PPGSF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ppgsf check failed");
`else
`define PPGSF_ASSERT(lbl, prop)
`define PPGSF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/core/ppgsf_pkg.sv =====
// types, register map and constants of the sample fifo core
// no dependencies
package ppgsf_pkg;

  localparam int FIFO_DEPTH  = 32;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int SAMPLE_BITS = 18;
  localparam int ENTRY_W     = 2 * SAMPLE_BITS;
  localparam int CHAN_W      = 24;
  localparam int LOST_W      = 5;

  localparam logic [LOST_W-1:0] LOST_MAX = 5'h1F;
  localparam int MODE_RESET_IDX = 6;
  localparam int ROLLOVER_IDX   = 4;
  localparam logic [2:0] MODE_OXIM = 3'h3;

  localparam logic [7:0] PART_IDENT     = 8'd21;
  localparam logic [7:0] REVISION_IDENT = 8'd1;

  localparam logic [7:0] ADDR_WR_PTR   = 8'h04;
  localparam logic [7:0] ADDR_LOST     = 8'h05;
  localparam logic [7:0] ADDR_RD_PTR   = 8'h06;
  localparam logic [7:0] ADDR_FIFO     = 8'h07;
  localparam logic [7:0] ADDR_FIFO_CFG = 8'h08;
  localparam logic [7:0] ADDR_MODE     = 8'h09;
  localparam logic [7:0] ADDR_SPO2     = 8'h0A;
  localparam logic [7:0] ADDR_RED_AMP  = 8'h0C;
  localparam logic [7:0] ADDR_IR_AMP   = 8'h0D;
  localparam logic [7:0] ADDR_REV_ID   = 8'hFE;
  localparam logic [7:0] ADDR_PART_ID  = 8'hFF;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_FIFO_RD
  } state_t;

endpackage

// ===== rtl/core/ppgsf_sample_ram.sv =====
// single port write, single port read sample memory with registered read data
// no dependencies
module ppgsf_sample_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 36
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/ppg_sensor_sample_fifo_registers_core.sv =====
// top level of the sample fifo core: register file, fifo control, output register
// uses ppgsf_pkg, ppgsf_sample_ram and the assertion macro header
//
// channel  dir  handshake         payload
// in_      in   in_valid/in_stall  op, reg_addr, write_data, red_sample, ir_sample
// out_     out  out_valid/out_stall read_data, sample_lost
//
// one result per transaction; register and sample accesses answer the cycle after accept
// non empty fifo data reads register the memory read first, then the output byte
// rst_n is synchronous; the sample memory itself is never cleared
// input is stalled while a fifo read waits on memory or a result is held by out_stall
`include "ppg_sensor_sample_fifo_registers_core_assert.svh"

module ppg_sensor_sample_fifo_registers_core
  import ppgsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_write_data,
  input  logic [17:0] in_red_sample,
  input  logic [17:0] in_ir_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_sample_lost
);

  state_t state_r, state_nxt;

  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [LOST_W-1:0] lost_r, lost_nxt;
  logic              full_r, full_nxt;
  logic [2:0]        byte_pos_r, byte_pos_nxt;
  logic [7:0]        fifo_cfg_r, fifo_cfg_nxt;
  logic [7:0]        mode_r, mode_nxt;
  logic [7:0]        spo2_r, spo2_nxt;
  logic [7:0]        red_amp_r, red_amp_nxt;
  logic [7:0]        ir_amp_r, ir_amp_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_lost_r, out_lost_nxt;

  logic              accept;
  logic              fifo_empty;
  logic              ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  assign in_stall   = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept     = in_valid && !in_stall;
  assign fifo_empty = !full_r && (wr_ptr_r == rd_ptr_r);
  assign ram_wdata  = {in_red_sample, in_ir_sample};

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_sample_lost = out_lost_r;

  ppgsf_sample_ram #(
    .DEPTH(FIFO_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(wr_ptr_r),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(rd_ptr_r),
    .rd_data(ram_rdata)
  );

  always_comb begin
    logic [SAMPLE_BITS-1:0] chan;
    logic [CHAN_W-1:0]      chan_ext;
    logic [PTR_W-1:0]       wr_inc;
    logic [7:0]             rd_byte;

    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    lost_nxt      = lost_r;
    full_nxt      = full_r;
    byte_pos_nxt  = byte_pos_r;
    fifo_cfg_nxt  = fifo_cfg_r;
    mode_nxt      = mode_r;
    spo2_nxt      = spo2_r;
    red_amp_nxt   = red_amp_r;
    ir_amp_nxt    = ir_amp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_lost_nxt  = out_lost_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    wr_inc        = wr_ptr_r + PTR_W'(1);
    rd_byte       = 8'h00;

    // byte of the pair under the read pointer, red channel first
    chan     = (byte_pos_r < 3'd3) ? ram_rdata[ENTRY_W-1:SAMPLE_BITS]
                                   : ram_rdata[SAMPLE_BITS-1:0];
    chan_ext = CHAN_W'(chan);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'h00;
          out_lost_nxt  = 1'b0;
          case (in_op)
            OP_WRITE: begin
              case (in_reg_addr)
                ADDR_WR_PTR: begin
                  wr_ptr_nxt   = in_write_data[PTR_W-1:0];
                  full_nxt     = 1'b0;
                  byte_pos_nxt = 3'd0;
                end
                ADDR_LOST: begin
                  lost_nxt     = in_write_data[LOST_W-1:0] & LOST_MAX;
                  full_nxt     = 1'b0;
                  byte_pos_nxt = 3'd0;
                end
                ADDR_RD_PTR: begin
                  rd_ptr_nxt   = in_write_data[PTR_W-1:0];
                  full_nxt     = 1'b0;
                  byte_pos_nxt = 3'd0;
                end
                ADDR_FIFO_CFG: fifo_cfg_nxt = in_write_data;
                ADDR_MODE: begin
                  if (in_write_data[MODE_RESET_IDX]) begin
                    // soft reset of the whole register file, stored pairs stay
                    wr_ptr_nxt   = '0;
                    rd_ptr_nxt   = '0;
                    lost_nxt     = '0;
                    full_nxt     = 1'b0;
                    byte_pos_nxt = 3'd0;
                    fifo_cfg_nxt = 8'h00;
                    mode_nxt     = 8'h00;
                    spo2_nxt     = 8'h00;
                    red_amp_nxt  = 8'h00;
                    ir_amp_nxt   = 8'h00;
                  end else begin
                    mode_nxt = in_write_data;
                  end
                end
                ADDR_SPO2:    spo2_nxt    = in_write_data;
                ADDR_RED_AMP: red_amp_nxt = in_write_data;
                ADDR_IR_AMP:  ir_amp_nxt  = in_write_data;
                default: ;
              endcase
            end
            OP_READ: begin
              case (in_reg_addr)
                ADDR_WR_PTR:   out_data_nxt = 8'(wr_ptr_r);
                ADDR_LOST:     out_data_nxt = 8'(lost_r);
                ADDR_RD_PTR:   out_data_nxt = 8'(rd_ptr_r);
                ADDR_FIFO: begin
                  if (!fifo_empty) begin
                    // result comes once the memory answers
                    ram_re        = 1'b1;
                    out_valid_nxt = 1'b0;
                    state_nxt     = ST_FIFO_RD;
                  end
                end
                ADDR_FIFO_CFG: out_data_nxt = fifo_cfg_r;
                ADDR_MODE:     out_data_nxt = mode_r;
                ADDR_SPO2:     out_data_nxt = spo2_r;
                ADDR_RED_AMP:  out_data_nxt = red_amp_r;
                ADDR_IR_AMP:   out_data_nxt = ir_amp_r;
                ADDR_REV_ID:   out_data_nxt = REVISION_IDENT;
                ADDR_PART_ID:  out_data_nxt = PART_IDENT;
                default:       out_data_nxt = 8'h00;
              endcase
            end
            OP_SAMPLE: begin
              if (mode_r[2:0] == MODE_OXIM) begin
                if (full_r) begin
                  out_lost_nxt = 1'b1;
                  if (lost_r < LOST_MAX) begin
                    lost_nxt = lost_r + LOST_W'(1);
                  end
                  if (fifo_cfg_r[ROLLOVER_IDX]) begin
                    // overwrite the oldest pair, fifo stays full
                    ram_we     = 1'b1;
                    wr_ptr_nxt = wr_inc;
                    rd_ptr_nxt = wr_inc;
                  end
                end else begin
                  ram_we     = 1'b1;
                  wr_ptr_nxt = wr_inc;
                  full_nxt   = (wr_inc == rd_ptr_r);
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIFO_RD: begin
        if (byte_pos_r inside {3'd0, 3'd3}) begin
          rd_byte = chan_ext[23:16];
        end else if (byte_pos_r inside {3'd1, 3'd4}) begin
          rd_byte = chan_ext[15:8];
        end else begin
          rd_byte = chan_ext[7:0];
        end
        if (byte_pos_r >= 3'd5) begin
          byte_pos_nxt = 3'd0;
          rd_ptr_nxt   = rd_ptr_r + PTR_W'(1);
          lost_nxt     = '0;
          full_nxt     = 1'b0;
        end else begin
          byte_pos_nxt = byte_pos_r + 3'd1;
        end
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_byte;
        out_lost_nxt  = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      lost_r      <= '0;
      full_r      <= 1'b0;
      byte_pos_r  <= 3'd0;
      fifo_cfg_r  <= 8'h00;
      mode_r      <= 8'h00;
      spo2_r      <= 8'h00;
      red_amp_r   <= 8'h00;
      ir_amp_r    <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      lost_r      <= lost_nxt;
      full_r      <= full_nxt;
      byte_pos_r  <= byte_pos_nxt;
      fifo_cfg_r  <= fifo_cfg_nxt;
      mode_r      <= mode_nxt;
      spo2_r      <= spo2_nxt;
      red_amp_r   <= red_amp_nxt;
      ir_amp_r    <= ir_amp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_lost_r <= out_lost_nxt;
  end

  // output slot is always free when a fifo read completes
  `PPGSF_ASSERT(a_fifo_rd_slot_free, (state_r == ST_FIFO_RD) |-> !out_valid_r)
  // every accepted transaction yields a result or a pending fifo read
  `PPGSF_ASSERT(a_accept_progress, accept |=> (out_valid_r || (state_r == ST_FIFO_RD)))
  // a full fifo always has matching pointers
  `PPGSF_ASSERT(a_full_ptrs, full_r |-> (wr_ptr_r == rd_ptr_r))
  // byte position stays within one pair
  `PPGSF_ASSERT(a_byte_pos_range, byte_pos_r <= 3'd5)
  // a sample transaction on a full fifo in MODE_OXIM always flags a lost sample
  `PPGSF_ASSERT(a_lost_cause,
    (accept && (in_op == OP_SAMPLE) && full_r && (mode_r[2:0] == MODE_OXIM))
      |=> out_sample_lost)

endmodule
